FILE: hdl/dpb_pkg.sv
// shared constants, register indexes and configuration struct for the back-projection block
package dpb_pkg;

    localparam int COEF_W          = 32;
    localparam int DEPTH_W         = 16;
    localparam int COLOR_W         = 8;
    localparam int OUT_W           = 24;
    localparam int FRAC_BITS       = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int COORD_WIDTH_DEF = 12;
    localparam int PIPE_DEPTH      = 4;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_KINV_XU   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_XV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_XC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_YV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_YC   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0]  kinv_xu;
        logic [COEF_W-1:0]  kinv_xv;
        logic [COEF_W-1:0]  kinv_xc;
        logic [COEF_W-1:0]  kinv_yv;
        logic [COEF_W-1:0]  kinv_yc;
        logic [DEPTH_W-1:0] max_depth_mm;
    } t_cfg;

endpackage

FILE: hdl/dpb_cfg_regs.sv
// configuration register file with a plain write port
module dpb_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dpb_pkg::t_cfg                   o_cfg
);

    dpb_pkg::t_cfg r_cfg;
    dpb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpb_pkg::REG_KINV_XU:   n_cfg.kinv_xu = i_cfg_data;
                dpb_pkg::REG_KINV_XV:   n_cfg.kinv_xv = i_cfg_data;
                dpb_pkg::REG_KINV_XC:   n_cfg.kinv_xc = i_cfg_data;
                dpb_pkg::REG_KINV_YV:   n_cfg.kinv_yv = i_cfg_data;
                dpb_pkg::REG_KINV_YC:   n_cfg.kinv_yc = i_cfg_data;
                dpb_pkg::REG_MAX_DEPTH: n_cfg.max_depth_mm = i_cfg_data[dpb_pkg::DEPTH_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kinv_xu      <= '0;
            r_cfg.kinv_xv      <= '0;
            r_cfg.kinv_xc      <= '0;
            r_cfg.kinv_yv      <= '0;
            r_cfg.kinv_yc      <= '0;
            r_cfg.max_depth_mm <= dpb_pkg::MAX_DEPTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/dpb_norm.sv
// two stages: coefficient products, then the normalized x and y sums in Q23.24
module dpb_norm #(
    parameter int COORD_WIDTH = dpb_pkg::COORD_WIDTH_DEF,
    localparam int PROD_W = dpb_pkg::COEF_W + COORD_WIDTH + 1,
    localparam int SUM_W  = PROD_W + 2
) (
    input  logic                    i_clk,
    input  logic [COORD_WIDTH-1:0]  i_column,
    input  logic [COORD_WIDTH-1:0]  i_row,
    input  dpb_pkg::t_cfg           i_cfg,
    output logic signed [SUM_W-1:0] o_sum_x,
    output logic signed [SUM_W-1:0] o_sum_y
);

    logic signed [PROD_W-1:0] r_pxu;
    logic signed [PROD_W-1:0] r_pxv;
    logic signed [PROD_W-1:0] r_pyv;
    logic signed [SUM_W-1:0]  r_sx;
    logic signed [SUM_W-1:0]  r_sy;
    logic signed [PROD_W-1:0] n_pxu;
    logic signed [PROD_W-1:0] n_pxv;
    logic signed [PROD_W-1:0] n_pyv;
    logic signed [SUM_W-1:0]  n_sx;
    logic signed [SUM_W-1:0]  n_sy;
    logic signed [COORD_WIDTH:0] w_u;
    logic signed [COORD_WIDTH:0] w_v;

    assign w_u = $signed({1'b0, i_column});
    assign w_v = $signed({1'b0, i_row});

    always_comb begin
        n_pxu = $signed(i_cfg.kinv_xu) * w_u;
        n_pxv = $signed(i_cfg.kinv_xv) * w_v;
        n_pyv = $signed(i_cfg.kinv_yv) * w_v;
        n_sx  = SUM_W'(r_pxu) + SUM_W'(r_pxv) + SUM_W'($signed(i_cfg.kinv_xc));
        n_sy  = SUM_W'(r_pyv) + SUM_W'($signed(i_cfg.kinv_yc));
    end

    always_ff @(posedge i_clk) begin
        r_pxu <= n_pxu;
        r_pxv <= n_pxv;
        r_pyv <= n_pyv;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
    end

    assign o_sum_x = r_sx;
    assign o_sum_y = r_sy;

endmodule

FILE: hdl/dpb_scale.sv
// two stages: split product of a Q23.24 sum by depth, then round half up and saturate
module dpb_scale #(
    parameter int SUM_W = dpb_pkg::COEF_W + dpb_pkg::COORD_WIDTH_DEF + 3,
    localparam int HI_W   = SUM_W - dpb_pkg::FRAC_BITS,
    localparam int LO_P_W = dpb_pkg::FRAC_BITS + dpb_pkg::DEPTH_W,
    localparam int HI_P_W = HI_W + dpb_pkg::DEPTH_W + 1,
    localparam int RND_W  = LO_P_W + 1 - dpb_pkg::FRAC_BITS,
    localparam int TOT_W  = HI_P_W + 1
) (
    input  logic                              i_clk,
    input  logic signed [SUM_W-1:0]           i_sum,
    input  logic [dpb_pkg::DEPTH_W-1:0]       i_z,
    output logic signed [dpb_pkg::OUT_W-1:0]  o_val
);

    localparam logic [LO_P_W:0] HALF = (LO_P_W + 1)'(1) << (dpb_pkg::FRAC_BITS - 1);
    localparam logic [dpb_pkg::OUT_W-1:0] SAT_MAX = {1'b0, {(dpb_pkg::OUT_W - 1){1'b1}}};
    localparam logic [dpb_pkg::OUT_W-1:0] SAT_MIN = {1'b1, {(dpb_pkg::OUT_W - 1){1'b0}}};

    logic [LO_P_W-1:0]         r_lo_p;
    logic signed [HI_P_W-1:0]  r_hi_p;
    logic [dpb_pkg::OUT_W-1:0] r_out;
    logic [LO_P_W-1:0]         n_lo_p;
    logic signed [HI_P_W-1:0]  n_hi_p;
    logic [dpb_pkg::OUT_W-1:0] n_out;
    logic [LO_P_W:0]           w_lo_r;
    logic [RND_W-1:0]          w_rnd;
    logic [TOT_W-1:0]          w_tot;
    logic [TOT_W-dpb_pkg::OUT_W:0] w_top;
    logic                      w_in_range;

    // s*z = hi*z*2^24 + lo*z, so the rounding only touches the low product
    always_comb begin
        n_lo_p     = LO_P_W'(i_sum[dpb_pkg::FRAC_BITS-1:0]) * LO_P_W'(i_z);
        n_hi_p     = $signed(i_sum[SUM_W-1:dpb_pkg::FRAC_BITS]) * $signed({1'b0, i_z});
        w_lo_r     = {1'b0, r_lo_p} + HALF;
        w_rnd      = w_lo_r[LO_P_W:dpb_pkg::FRAC_BITS];
        w_tot      = TOT_W'(r_hi_p) + TOT_W'(w_rnd);
        w_top      = w_tot[TOT_W-1:dpb_pkg::OUT_W-1];
        w_in_range = (&w_top) || (~|w_top);
        if (w_in_range) begin
            n_out = w_tot[dpb_pkg::OUT_W-1:0];
        end else if (w_tot[TOT_W-1]) begin
            n_out = SAT_MIN;
        end else begin
            n_out = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_p <= n_lo_p;
        r_hi_p <= n_hi_p;
        r_out  <= n_out;
    end

    assign o_val = $signed(r_out);

endmodule

FILE: hdl/depth_pixel_backprojection.sv
// top level: depth pixel to camera-frame point, four-stage pipeline
//
// usage:
//   a pixel transfer happens at a rising edge with start high and busy low;
//   busy is never raised, so one pixel may enter every clock cycle
//   a pixel is kept when mask is set, depth is nonzero, below max_depth_mm
//   and not flagged as not-a-number; dropped pixels give no output
//   a kept pixel gives one point on the o_ ports with o_valid high for exactly
//   one cycle, once it has passed all pipeline stages (the next edge takes it)
//   X and Y are rounded half up and saturated to 24 bits signed
//   throughput: one point per cycle; latency is set by two multiply stages,
//   one sum stage and one round/saturate stage
//   the receiver has no stall input and must take every point as shown
//   configuration writes land at the next edge with no handshake; change
//   registers only while no pixel is in flight
//   reset (synchronous, active low) clears the pipeline valid bits, sets the
//   coefficients to zero and the depth limit to 10000 mm
module depth_pixel_backprojection #(
    parameter int COORD_WIDTH = dpb_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [COORD_WIDTH-1:0]               i_pixel_column,
    input  logic [COORD_WIDTH-1:0]               i_pixel_row,
    input  logic [dpb_pkg::DEPTH_W-1:0]          i_depth_mm,
    input  logic                                 i_depth_not_number,
    input  logic                                 i_mask_bit,
    input  logic [dpb_pkg::COLOR_W-1:0]          i_blue_in,
    input  logic [dpb_pkg::COLOR_W-1:0]          i_green_in,
    input  logic [dpb_pkg::COLOR_W-1:0]          i_red_in,
    output logic                                 o_valid,
    output logic signed [dpb_pkg::OUT_W-1:0]     o_point_x_mm,
    output logic signed [dpb_pkg::OUT_W-1:0]     o_point_y_mm,
    output logic [dpb_pkg::DEPTH_W-1:0]          o_point_z_mm,
    output logic [dpb_pkg::COLOR_W-1:0]          o_red_out,
    output logic [dpb_pkg::COLOR_W-1:0]          o_green_out,
    output logic [dpb_pkg::COLOR_W-1:0]          o_blue_out
);

    localparam int SUM_W = dpb_pkg::COEF_W + COORD_WIDTH + 3;

    typedef struct packed {
        logic [dpb_pkg::DEPTH_W-1:0] z;
        logic [dpb_pkg::COLOR_W-1:0] red;
        logic [dpb_pkg::COLOR_W-1:0] green;
        logic [dpb_pkg::COLOR_W-1:0] blue;
    } t_side;

    dpb_pkg::t_cfg           w_cfg;
    logic                    w_keep;
    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;
    logic [dpb_pkg::PIPE_DEPTH-1:0] r_vld;
    logic [dpb_pkg::PIPE_DEPTH-1:0] n_vld;
    t_side                   r_side [dpb_pkg::PIPE_DEPTH];
    t_side                   n_side0;

    assign busy = 1'b0;

    dpb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_keep = start && !busy && i_mask_bit && !i_depth_not_number
                    && (i_depth_mm != '0) && (i_depth_mm < w_cfg.max_depth_mm);

    always_comb begin
        n_vld         = {r_vld[dpb_pkg::PIPE_DEPTH-2:0], w_keep};
        n_side0.z     = i_depth_mm;
        n_side0.red   = i_red_in;
        n_side0.green = i_green_in;
        n_side0.blue  = i_blue_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side0;
        for (int i = 1; i < dpb_pkg::PIPE_DEPTH; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    dpb_norm #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_norm (
        .i_clk    (i_clk),
        .i_column (i_pixel_column),
        .i_row    (i_pixel_row),
        .i_cfg    (w_cfg),
        .o_sum_x  (w_sum_x),
        .o_sum_y  (w_sum_y)
    );

    // depth for the scale stage comes from the sideband entry lined up with the sums
    dpb_scale #(
        .SUM_W (SUM_W)
    ) u_scale_x (
        .i_clk (i_clk),
        .i_sum (w_sum_x),
        .i_z   (r_side[1].z),
        .o_val (o_point_x_mm)
    );

    dpb_scale #(
        .SUM_W (SUM_W)
    ) u_scale_y (
        .i_clk (i_clk),
        .i_sum (w_sum_y),
        .i_z   (r_side[1].z),
        .o_val (o_point_y_mm)
    );

    assign o_valid      = r_vld[dpb_pkg::PIPE_DEPTH-1];
    assign o_point_z_mm = r_side[dpb_pkg::PIPE_DEPTH-1].z;
    assign o_red_out    = r_side[dpb_pkg::PIPE_DEPTH-1].red;
    assign o_green_out  = r_side[dpb_pkg::PIPE_DEPTH-1].green;
    assign o_blue_out   = r_side[dpb_pkg::PIPE_DEPTH-1].blue;

    a_no_busy : assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

    a_out_from_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start, 4) && $past(i_mask_bit, 4) && !$past(i_depth_not_number, 4)))
        else $error("point without a kept pixel four cycles earlier");

    a_out_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point_z_mm != '0 && o_point_z_mm == $past(i_depth_mm, 4)))
        else $error("point depth does not match its pixel");

endmodule

FILE: tb/sv/depth_pixel_backprojection_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the depth pixel back-projection block: directed table, then random pixels
module depth_pixel_backprojection_tb;

    localparam int COORD_W        = dpb_pkg::COORD_WIDTH_DEF;
    localparam int PIPE_DEPTH     = dpb_pkg::PIPE_DEPTH;
    localparam int CFG_IDX_W      = dpb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = dpb_pkg::CFG_DATA_W;
    localparam int FRAC_BITS      = dpb_pkg::FRAC_BITS;
    localparam int OUT_W          = dpb_pkg::OUT_W;
    localparam int DEPTH_W        = dpb_pkg::DEPTH_W;
    localparam int COLOR_W        = dpb_pkg::COLOR_W;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = PIPE_DEPTH + 2;
    localparam int RAND_BLOCKS    = 14;
    localparam int BLOCK_PIXELS   = 100;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_KINV_XU   = dpb_pkg::REG_KINV_XU;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_XV   = dpb_pkg::REG_KINV_XV;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_XC   = dpb_pkg::REG_KINV_XC;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_YV   = dpb_pkg::REG_KINV_YV;
    localparam logic [CFG_IDX_W-1:0] REG_KINV_YC   = dpb_pkg::REG_KINV_YC;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = dpb_pkg::REG_MAX_DEPTH;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

    localparam logic signed [95:0] WIDE_HALF = 96'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [95:0] WIDE_MAX  = (96'sd1 <<< (OUT_W - 1)) - 96'sd1;
    localparam logic signed [95:0] WIDE_MIN  = -(96'sd1 <<< (OUT_W - 1));

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [DEPTH_W-1:0] depth;
        logic               not_number;
        logic               mask;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [DEPTH_W-1:0]      z;
        logic [COLOR_W-1:0]      red;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      blue;
    } t_point;

    typedef enum logic [1:0] {ROW_WRITE, ROW_CHECK, ROW_FIXED, ROW_DROP} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        t_pixel                  pix;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [OUT_W-1:0] want_x;
        logic signed [OUT_W-1:0] want_y;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic [COORD_W-1:0]      i_pixel_column = '0;
    logic [COORD_W-1:0]      i_pixel_row = '0;
    logic [DEPTH_W-1:0]      i_depth_mm = '0;
    logic                    i_depth_not_number = 1'b0;
    logic                    i_mask_bit = 1'b0;
    logic [COLOR_W-1:0]      i_blue_in = '0;
    logic [COLOR_W-1:0]      i_green_in = '0;
    logic [COLOR_W-1:0]      i_red_in = '0;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_point_x_mm;
    logic signed [OUT_W-1:0] o_point_y_mm;
    logic [DEPTH_W-1:0]      o_point_z_mm;
    logic [COLOR_W-1:0]      o_red_out;
    logic [COLOR_W-1:0]      o_green_out;
    logic [COLOR_W-1:0]      o_blue_out;

    dpb_pkg::t_cfg shadow_cfg;
    t_point        pending_points[$];
    t_row          steps[$];
    int            mismatch_count = 0;
    int            stall_cycles = 0;

    depth_pixel_backprojection #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pixel_column(i_pixel_column),
        .i_pixel_row(i_pixel_row),
        .i_depth_mm(i_depth_mm),
        .i_depth_not_number(i_depth_not_number),
        .i_mask_bit(i_mask_bit),
        .i_blue_in(i_blue_in),
        .i_green_in(i_green_in),
        .i_red_in(i_red_in),
        .o_valid(o_valid),
        .o_point_x_mm(o_point_x_mm),
        .o_point_y_mm(o_point_y_mm),
        .o_point_z_mm(o_point_z_mm),
        .o_red_out(o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out(o_blue_out)
    );

    always #2 i_clk = ~i_clk;

    // exact Q40.24 sum times depth, rounded half up, clipped to the output range
    function automatic logic signed [OUT_W-1:0] round_to_mm(longint q_sum, logic [DEPTH_W-1:0] z);
        logic signed [95:0] prod;
        logic signed [95:0] scaled;
        prod   = q_sum;
        prod   = prod * $signed({80'd0, z});
        scaled = (prod + WIDE_HALF) >>> FRAC_BITS;
        if (scaled > WIDE_MAX) begin
            return WIDE_MAX[OUT_W-1:0];
        end
        if (scaled < WIDE_MIN) begin
            return WIDE_MIN[OUT_W-1:0];
        end
        return scaled[OUT_W-1:0];
    endfunction

    function automatic bit project_pixel(input t_pixel p, output t_point pt);
        longint uu;
        longint vv;
        longint sum_x;
        longint sum_y;
        pt = '0;
        if (!p.mask || p.not_number || p.depth == '0 || p.depth >= shadow_cfg.max_depth_mm) begin
            return 1'b0;
        end
        uu    = longint'(p.column);
        vv    = longint'(p.row);
        sum_x = longint'($signed(shadow_cfg.kinv_xu)) * uu
              + longint'($signed(shadow_cfg.kinv_xv)) * vv
              + longint'($signed(shadow_cfg.kinv_xc));
        sum_y = longint'($signed(shadow_cfg.kinv_yv)) * vv
              + longint'($signed(shadow_cfg.kinv_yc));
        pt.x     = round_to_mm(sum_x, p.depth);
        pt.y     = round_to_mm(sum_y, p.depth);
        pt.z     = p.depth;
        pt.red   = p.red;
        pt.green = p.green;
        pt.blue  = p.blue;
        return 1'b1;
    endfunction

    function automatic t_pixel px(int col, int row, int depth, bit nan, bit mask,
                                  int blue, int green, int red);
        t_pixel p;
        p.column     = COORD_W'(col);
        p.row        = COORD_W'(row);
        p.depth      = DEPTH_W'(depth);
        p.not_number = nan;
        p.mask       = mask;
        p.blue       = COLOR_W'(blue);
        p.green      = COLOR_W'(green);
        p.red        = COLOR_W'(red);
        return p;
    endfunction

    function automatic t_row pixel_row(t_row_kind kind, t_pixel p, int want_x = 0,
                                       int want_y = 0);
        t_row r;
        r.kind   = kind;
        r.pix    = p;
        r.idx    = '0;
        r.data   = '0;
        r.want_x = OUT_W'(want_x);
        r.want_y = OUT_W'(want_y);
        return r;
    endfunction

    function automatic t_row write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r      = pixel_row(ROW_WRITE, '0);
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coef();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(0, (1 << 23) - 1)) - 32'(1 << 22);
            2: return 32'($urandom_range(0, (1 << 17) - 1)) - 32'(1 << 16);
            default: return 32'($urandom_range(0, (1 << 13) - 1)) - 32'(1 << 12);
        endcase
    endfunction

    // upper half of the data word is don't-care for the depth limit
    function automatic logic [CFG_DATA_W-1:0] random_limit();
        logic [DEPTH_W-1:0] lim;
        case ($urandom_range(7))
            0: lim = '1;
            1: lim = DEPTH_W'($urandom_range(1, 16));
            default: lim = DEPTH_W'($urandom_range(256, 65535));
        endcase
        return {16'($urandom), lim};
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        logic [DEPTH_W-1:0] lim;
        lim          = shadow_cfg.max_depth_mm;
        p.column     = COORD_W'($urandom);
        p.row        = COORD_W'($urandom);
        p.not_number = ($urandom_range(15) == 0);
        p.mask       = ($urandom_range(15) != 0);
        p.blue       = COLOR_W'($urandom);
        p.green      = COLOR_W'($urandom);
        p.red        = COLOR_W'($urandom);
        case ($urandom_range(9))
            0: p.depth = '0;
            1: p.depth = lim;
            2: p.depth = DEPTH_W'($urandom);
            default: begin
                if (lim > 1) begin
                    p.depth = DEPTH_W'($urandom_range(1, lim - 1));
                end else begin
                    p.depth = DEPTH_W'($urandom);
                end
            end
        endcase
        return p;
    endfunction

    task automatic queue_step(t_row r);
        steps = {steps, r};
    endtask

    task automatic expect_point(t_point pt);
        pending_points = {pending_points, pt};
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        start      <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_KINV_XU:   shadow_cfg.kinv_xu = data;
            REG_KINV_XV:   shadow_cfg.kinv_xv = data;
            REG_KINV_XC:   shadow_cfg.kinv_xc = data;
            REG_KINV_YV:   shadow_cfg.kinv_yv = data;
            REG_KINV_YC:   shadow_cfg.kinv_yc = data;
            REG_MAX_DEPTH: shadow_cfg.max_depth_mm = data[DEPTH_W-1:0];
            default: ;
        endcase
    endtask

    // returns at the edge where the pixel transfer happens
    task automatic send_pixel(t_pixel p);
        @(negedge i_clk);
        start              <= 1'b1;
        i_cfg_we           <= 1'b0;
        i_pixel_column     <= p.column;
        i_pixel_row        <= p.row;
        i_depth_mm         <= p.depth;
        i_depth_not_number <= p.not_number;
        i_mask_bit         <= p.mask;
        i_blue_in          <= p.blue;
        i_green_in         <= p.green;
        i_red_in           <= p.red;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic rest_cycle();
        @(negedge i_clk);
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
    endtask

    // dropped pixels may still be in the pipe after the last point, so allow for them
    task automatic wait_drained();
        rest_cycle();
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid) begin
            if (pending_points.size() == 0) begin
                report_mismatch("point with no pixel waiting for it");
            end else begin
                want = pending_points.pop_front();
                check_field("x", $signed(o_point_x_mm), $signed(want.x));
                check_field("y", $signed(o_point_y_mm), $signed(want.y));
                check_field("z", o_point_z_mm, want.z);
                check_field("red", o_red_out, want.red);
                check_field("green", o_green_out, want.green);
                check_field("blue", o_blue_out, want.blue);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("timeout, %0d points still expected", pending_points.size());
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_pixel pix;
        t_point pt;
        int     idle_pct;

        shadow_cfg = '{kinv_xu: '0, kinv_xv: '0, kinv_xc: '0, kinv_yv: '0, kinv_yc: '0,
                       max_depth_mm: dpb_pkg::MAX_DEPTH_RST};

        // reset values: zero coefficients give a point on the optical axis
        queue_step(pixel_row(ROW_FIXED, px(0, 0, 1, 0, 1, 8'h00, 8'h00, 8'h00), 0, 0));
        queue_step(pixel_row(ROW_FIXED, px(4095, 4095, 9999, 0, 1, 8'hff, 8'hff, 8'hff), 0, 0));
        queue_step(pixel_row(ROW_DROP, px(10, 10, 10000, 0, 1, 8'h11, 8'h22, 8'h33)));
        queue_step(pixel_row(ROW_DROP, px(10, 10, 0, 0, 1, 8'h11, 8'h22, 8'h33)));
        queue_step(pixel_row(ROW_DROP, px(10, 10, 500, 1, 1, 8'h11, 8'h22, 8'h33)));
        queue_step(pixel_row(ROW_DROP, px(10, 10, 500, 0, 0, 8'h11, 8'h22, 8'h33)));
        // largest positive coefficients, full depth range
        queue_step(write_row(REG_KINV_XU, 32'h7fff_ffff));
        queue_step(write_row(REG_KINV_XV, 32'h7fff_ffff));
        queue_step(write_row(REG_KINV_XC, 32'h7fff_ffff));
        queue_step(write_row(REG_KINV_YV, 32'h7fff_ffff));
        queue_step(write_row(REG_KINV_YC, 32'h7fff_ffff));
        queue_step(write_row(REG_MAX_DEPTH, 32'hffff_ffff));
        queue_step(pixel_row(ROW_FIXED, px(4095, 4095, 65534, 0, 1, 8'h5a, 8'ha5, 8'h3c),
                             8388607, 8388607));
        queue_step(pixel_row(ROW_CHECK, px(0, 0, 1, 0, 1, 8'h01, 8'h02, 8'h03)));
        // most negative coefficients
        queue_step(write_row(REG_KINV_XU, 32'h8000_0000));
        queue_step(write_row(REG_KINV_XV, 32'h8000_0000));
        queue_step(write_row(REG_KINV_XC, 32'h8000_0000));
        queue_step(write_row(REG_KINV_YV, 32'h8000_0000));
        queue_step(write_row(REG_KINV_YC, 32'h8000_0000));
        queue_step(pixel_row(ROW_FIXED, px(4095, 4095, 65534, 0, 1, 8'hc3, 8'h3c, 8'h96),
                             -8388608, -8388608));
        queue_step(pixel_row(ROW_CHECK, px(0, 0, 1, 0, 1, 8'h80, 8'h40, 8'h20)));
        // a VGA-like camera
        queue_step(write_row(REG_KINV_XU, 32'd31957));
        queue_step(write_row(REG_KINV_XV, 32'd0));
        queue_step(write_row(REG_KINV_XC, -32'sd10210124));
        queue_step(write_row(REG_KINV_YV, 32'd31957));
        queue_step(write_row(REG_KINV_YC, -32'sd7653580));
        queue_step(pixel_row(ROW_CHECK, px(320, 240, 1500, 0, 1, 8'h12, 8'h34, 8'h56)));
        queue_step(pixel_row(ROW_CHECK, px(0, 0, 9999, 0, 1, 8'h9a, 8'hbc, 8'hde)));
        queue_step(pixel_row(ROW_CHECK, px(639, 479, 2000, 0, 1, 8'h0f, 8'hf0, 8'h55)));
        // plus and minus one half: exact ties round up
        queue_step(write_row(REG_KINV_XU, 32'd0));
        queue_step(write_row(REG_KINV_XV, 32'd0));
        queue_step(write_row(REG_KINV_XC, 32'h0080_0000));
        queue_step(write_row(REG_KINV_YV, 32'd0));
        queue_step(write_row(REG_KINV_YC, 32'hff80_0000));
        queue_step(pixel_row(ROW_FIXED, px(7, 7, 1, 0, 1, 8'h21, 8'h43, 8'h65), 1, 0));
        queue_step(pixel_row(ROW_FIXED, px(100, 200, 3, 0, 1, 8'h87, 8'ha9, 8'hcb), 2, -1));
        // writes to unmapped indexes must leave every register alone
        queue_step(write_row(REG_UNMAPPED_A, 32'hffff_ffff));
        queue_step(write_row(REG_UNMAPPED_B, 32'h0000_0001));
        queue_step(pixel_row(ROW_FIXED, px(1, 1, 3, 0, 1, 8'hed, 8'hcb, 8'ha9), 2, -1));
        // zero depth limit keeps nothing; a limit of one keeps nothing either, a limit of two keeps only depth one
        queue_step(write_row(REG_MAX_DEPTH, 32'hffff_0000));
        queue_step(pixel_row(ROW_DROP, px(1, 1, 1, 0, 1, 8'h01, 8'h01, 8'h01)));
        queue_step(pixel_row(ROW_DROP, px(4095, 4095, 65535, 0, 1, 8'hfe, 8'hfe, 8'hfe)));
        queue_step(write_row(REG_MAX_DEPTH, 32'd1));
        queue_step(pixel_row(ROW_DROP, px(2, 3, 1, 0, 1, 8'h44, 8'h55, 8'h66)));
        queue_step(write_row(REG_MAX_DEPTH, 32'd2));
        queue_step(pixel_row(ROW_FIXED, px(5, 5, 1, 0, 1, 8'h77, 8'h88, 8'h99), 1, 0));
        queue_step(pixel_row(ROW_DROP, px(5, 5, 2, 0, 1, 8'h77, 8'h88, 8'h99)));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            case (steps[i].kind)
                ROW_WRITE: begin
                    if (i == 0 || steps[i-1].kind != ROW_WRITE) begin
                        wait_drained();
                    end
                    write_reg(steps[i].idx, steps[i].data);
                end
                ROW_CHECK: begin
                    send_pixel(steps[i].pix);
                    if (project_pixel(steps[i].pix, pt)) begin
                        expect_point(pt);
                    end
                end
                ROW_FIXED: begin
                    send_pixel(steps[i].pix);
                    pt.x     = steps[i].want_x;
                    pt.y     = steps[i].want_y;
                    pt.z     = steps[i].pix.depth;
                    pt.red   = steps[i].pix.red;
                    pt.green = steps[i].pix.green;
                    pt.blue  = steps[i].pix.blue;
                    expect_point(pt);
                end
                default: begin
                    send_pixel(steps[i].pix);
                end
            endcase
        end

        // random part: new settings per block, sender idle odds 34 then 73 then 0 percent
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            wait_drained();
            write_reg(REG_KINV_XU, random_coef());
            write_reg(REG_KINV_XV, random_coef());
            write_reg(REG_KINV_XC, random_coef());
            write_reg(REG_KINV_YV, random_coef());
            write_reg(REG_KINV_YC, random_coef());
            write_reg(REG_MAX_DEPTH, random_limit());
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, $urandom);
            end
            idle_pct = (blk < 5) ? 34 : (blk < 10) ? 73 : 0;
            for (int n = 0; n < BLOCK_PIXELS; n++) begin
                while ($urandom_range(99) < idle_pct) rest_cycle();
                pix = random_pixel();
                send_pixel(pix);
                if (project_pixel(pix, pt)) begin
                    expect_point(pt);
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
